>>> hdl/ugbi_pkg.sv
// Shared types and codes for the uniform grid bin index.
// No dependencies; imported by all hdl modules of the block.
package ugbi_pkg;
    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_VISIT = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd1;
    localparam logic [2:0] REG_CELL_W   = 3'd2;
    localparam logic [2:0] REG_CELL_H   = 3'd3;
    localparam logic [2:0] REG_ACROSS   = 3'd4;
    localparam logic [2:0] REG_DOWN     = 3'd5;

    localparam int QW = 33;   // width of an offset from the origin
endpackage

>>> hdl/ugbi_div.sv
// Radix-2 restoring divider that turns an origin offset into a cell index.
// Depends on ugbi_pkg for the offset width.
module ugbi_div
    import ugbi_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [QW-1:0] dividend,
    input  logic [30:0]   divisor,
    output logic          done,
    output logic [QW-1:0] quotient
);
    logic [QW-1:0] q_reg;
    logic [31:0]   r_reg;
    logic [30:0]   d_reg;
    logic [5:0]    n_reg;
    logic          busy_reg;
    logic [32:0]   trial;

    assign trial    = {r_reg, q_reg[QW-1]} - {2'b0, d_reg};
    assign quotient = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            n_reg    <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                q_reg    <= dividend;
                r_reg    <= '0;
                d_reg    <= (divisor == '0) ? 31'd1 : divisor;
                n_reg    <= 6'(QW);
            end else if (busy_reg) begin
                if (!trial[32]) begin
                    r_reg <= trial[31:0];
                    q_reg <= {q_reg[QW-2:0], 1'b1};
                end else begin
                    r_reg <= {r_reg[30:0], q_reg[QW-1]};
                    q_reg <= {q_reg[QW-2:0], 1'b0};
                end
                n_reg <= n_reg - 6'd1;
                if (n_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
endmodule

>>> hdl/uniform_grid_bin_index.sv
// Top level of the uniform grid bin index: control sequencer and cell memories.
// Depends on ugbi_pkg and instantiates ugbi_div.
//
// Requests arrive on the s_ channel, one at a time. An add or a visit first
// turns its four box corners into cell indexes with one shared serial divider,
// then walks the covered cells in row-major order. For each cell the count
// memory is read and its registered data is checked; an add writes the entry
// and the new count back in that same check cycle. An add gives one result;
// a visit gives one result per cell, with m_tlast on the final one. A visit
// presents each result in S_OUT and waits there as long as the receiver
// holds m_tready low, since each result sits in the output register until
// taken. A read passes through S_RCHK and S_RDATA to its result in S_OUT.
// After reset the counts are cleared by a pass over the count memory, one
// cell a cycle, while s_tready stays low.
// Configuration writes are taken at any time and should come while idle.
module uniform_grid_bin_index
    import ugbi_pkg::*;
#(
    parameter int MAX_COLUMNS   = 8,
    parameter int MAX_ROWS      = 8,
    parameter int CELL_CAPACITY = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata from bit 0: action(2) object_id(20) box_min_x(32) box_min_z(32)
    // box_max_x(32) box_max_z(32) read_cell_x(3) read_cell_z(3) read_slot(5), pad
    input  logic [167:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata from bit 0: status(2) cell_x(3) cell_z(3) entry_count(6) entry_id(20), pad
    output logic [39:0]  m_tdata,
    output logic         m_tlast
);
    localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int NC  = MAX_COLUMNS * MAX_ROWS;
    localparam int NCW = (NC > 1) ? $clog2(NC) : 1;
    localparam int SW  = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
    localparam int KW  = $clog2(CELL_CAPACITY + 1);
    localparam int EW  = NCW + SW;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_DWAIT, S_CRD, S_CCHK, S_RCHK, S_RDATA,
        S_OUT, S_DONE
    } state_t;

    state_t state_reg;
    logic [31:0] org_x_reg, org_z_reg;
    logic [30:0] cw_reg, ch_reg;
    logic [3:0]  across_reg, down_reg;

    logic [1:0]  act_reg;
    logic [19:0] fid_reg;
    logic [31:0] coord_reg [4];
    logic [1:0]  corner_reg;
    logic [7:0]  cx0_reg, cx1_reg, cz0_reg, cz1_reg, cx_reg, cz_reg;
    logic [2:0]  rx_reg, rz_reg;
    logic [4:0]  rslot_reg;
    logic [NCW-1:0] clr_reg;

    logic [KW-1:0] cnt_mem [NC];
    logic [19:0]   ent_mem [NC*CELL_CAPACITY];
    logic [KW-1:0] cnt_rd;
    logic [19:0]   ent_rd;
    logic          cnt_we;
    logic [NCW-1:0] cnt_wa, cnt_ra;
    logic [KW-1:0] cnt_wd;
    logic          ent_we;
    logic [EW-1:0] ent_wa, ent_ra;

    logic [1:0]  o_st_reg;
    logic [2:0]  o_x_reg, o_z_reg;
    logic [5:0]  o_cnt_reg;
    logic [19:0] o_id_reg;
    logic        o_last_reg, o_done_reg;

    // Limited grid dimensions.
    logic [7:0] cols, rows;
    always_comb begin
        cols = (across_reg == 4'd0) ? 8'd1 : 8'(across_reg);
        if (cols > 8'(MAX_COLUMNS)) cols = 8'(MAX_COLUMNS);
        rows = (down_reg == 4'd0) ? 8'd1 : 8'(down_reg);
        if (rows > 8'(MAX_ROWS)) rows = 8'(MAX_ROWS);
    end

    // Divider hookup: corners 0,2 are x, 1,3 are z.
    logic          dv_start, dv_done;
    logic [QW-1:0] dv_q;
    logic [32:0]   diff;
    logic          is_z;
    assign is_z = corner_reg[0];
    assign diff = {coord_reg[corner_reg][31], coord_reg[corner_reg]}
                - (is_z ? {org_z_reg[31], org_z_reg} : {org_x_reg[31], org_x_reg});

    ugbi_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start),
        .dividend(diff[32] ? '0 : diff), .divisor(is_z ? ch_reg : cw_reg),
        .done(dv_done), .quotient(dv_q)
    );

    logic [7:0] lim, qcl;
    always_comb begin
        lim = is_z ? rows - 8'd1 : cols - 8'd1;
        qcl = (dv_q > QW'(lim)) ? lim : dv_q[7:0];
    end

    logic [NCW-1:0] cur_cell, rd_cell;
    assign cur_cell = NCW'(cz_reg[RW-1:0] * MAX_COLUMNS + cx_reg[CW-1:0]);
    assign rd_cell  = NCW'(rz_reg * MAX_COLUMNS + rx_reg);

    // Memories.
    always_ff @(posedge aclk) begin
        if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
        cnt_rd <= cnt_mem[cnt_ra];
        if (ent_we) ent_mem[ent_wa] <= fid_reg;
        ent_rd <= ent_mem[ent_ra];
    end

    always_comb begin
        cnt_ra = (state_reg == S_IDLE || state_reg == S_RCHK) ? rd_cell : cur_cell;
        ent_ra = EW'(rd_cell * CELL_CAPACITY + rslot_reg);
        cnt_we = 1'b0;
        cnt_wa = cur_cell;
        cnt_wd = cnt_rd + KW'(1);
        ent_we = 1'b0;
        ent_wa = EW'(cur_cell * CELL_CAPACITY + cnt_rd);
        if (state_reg == S_CLEAR) begin
            cnt_we = 1'b1;
            cnt_wa = clr_reg;
            cnt_wd = '0;
        end else if (state_reg == S_CCHK && act_reg == ACT_ADD
                     && cnt_rd < KW'(CELL_CAPACITY)) begin
            cnt_we = 1'b1;
            ent_we = 1'b1;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign dv_start = (state_reg == S_DIV);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {6'd0, o_id_reg, o_cnt_reg, o_z_reg, o_x_reg, o_st_reg};
    assign m_tlast  = o_last_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_x_reg <= '0; org_z_reg <= '0;
            cw_reg <= 31'd256; ch_reg <= 31'd256;
            across_reg <= 4'd8; down_reg <= 4'd8;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ORIGIN_X: org_x_reg  <= cfg_wdata;
                REG_ORIGIN_Z: org_z_reg  <= cfg_wdata;
                REG_CELL_W:   cw_reg     <= cfg_wdata[30:0];
                REG_CELL_H:   ch_reg     <= cfg_wdata[30:0];
                REG_ACROSS:   across_reg <= cfg_wdata[3:0];
                REG_DOWN:     down_reg   <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    logic fin;
    assign fin = (cx_reg == cx1_reg) && (cz_reg == cz1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end else begin
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + NCW'(1);
                    if (clr_reg == NCW'(NC - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: if (s_tvalid) begin
                    act_reg      <= s_tdata[1:0];
                    fid_reg      <= s_tdata[21:2];
                    coord_reg[0] <= s_tdata[53:22];
                    coord_reg[1] <= s_tdata[85:54];
                    coord_reg[2] <= s_tdata[117:86];
                    coord_reg[3] <= s_tdata[149:118];
                    rx_reg       <= s_tdata[152:150];
                    rz_reg       <= s_tdata[155:153];
                    rslot_reg    <= s_tdata[160:156];
                    corner_reg   <= 2'd0;
                    case (s_tdata[1:0])
                        ACT_ADD, ACT_VISIT: state_reg <= S_DIV;
                        ACT_READ:           state_reg <= S_RCHK;
                        default:            state_reg <= S_IDLE;
                    endcase
                end
                S_DIV: state_reg <= S_DWAIT;
                S_DWAIT: if (dv_done) begin
                    case (corner_reg)
                        2'd0: cx0_reg <= qcl;
                        2'd1: cz0_reg <= qcl;
                        2'd2: cx1_reg <= qcl;
                        default: cz1_reg <= qcl;
                    endcase
                    corner_reg <= corner_reg + 2'd1;
                    if (corner_reg == 2'd3) begin
                        cx_reg <= cx0_reg;
                        cz_reg <= cz0_reg;
                        if (cx0_reg > cx1_reg || cz0_reg > qcl) begin
                            o_st_reg <= ST_OK; o_x_reg <= '0; o_z_reg <= '0;
                            o_cnt_reg <= '0; o_id_reg <= '0; o_last_reg <= 1'b1;
                            o_done_reg <= 1'b1;
                            state_reg <= (act_reg == ACT_ADD) ? S_OUT : S_IDLE;
                        end else begin
                            state_reg <= S_CRD;
                        end
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_CRD: state_reg <= S_CCHK;
                S_CCHK: begin
                    o_x_reg <= 3'(cx_reg); o_z_reg <= 3'(cz_reg);
                    o_cnt_reg <= 6'(cnt_rd); o_id_reg <= '0;
                    o_st_reg <= ST_OK; o_last_reg <= 1'b1;
                    if (cx_reg == cx1_reg) begin
                        cx_reg <= cx0_reg; cz_reg <= cz_reg + 8'd1;
                    end else begin
                        cx_reg <= cx_reg + 8'd1;
                    end
                    if (act_reg == ACT_ADD) begin
                        if (cnt_rd >= KW'(CELL_CAPACITY)) begin
                            o_st_reg <= ST_FULL; o_done_reg <= 1'b1;
                            state_reg <= S_OUT;
                        end else if (fin) begin
                            o_x_reg <= '0; o_z_reg <= '0; o_cnt_reg <= '0;
                            o_done_reg <= 1'b1; state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_CRD;
                        end
                    end else begin
                        o_last_reg <= fin; o_done_reg <= fin;
                        state_reg <= S_OUT;
                    end
                end
                S_RCHK: state_reg <= S_RDATA;
                S_RDATA: begin
                    o_x_reg <= rx_reg; o_z_reg <= rz_reg;
                    o_last_reg <= 1'b1; o_done_reg <= 1'b1;
                    o_id_reg <= '0; o_st_reg <= ST_RANGE;
                    if (8'(rx_reg) >= cols || 8'(rz_reg) >= rows) begin
                        o_cnt_reg <= '0;
                    end else begin
                        o_cnt_reg <= 6'(cnt_rd);
                        // The count never exceeds the capacity, so this also
                        // keeps the slot inside the cell.
                        if (KW'(rslot_reg) < cnt_rd) begin
                            o_st_reg <= ST_OK; o_id_reg <= ent_rd;
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: if (m_tready) state_reg <= o_done_reg ? S_IDLE : S_CRD;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
